/* sv/gthq_pkg.sv */
// Shared types, widths and codes for the grid triangle height query core.
`default_nettype none

package gthq_pkg;

    localparam int MAX_CELLS   = 64;
    localparam int IDX_W       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int STORE_CELLS = MAX_CELLS * MAX_CELLS;
    localparam int CELL_AW     = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;

    localparam int CNT_W    = 7;
    localparam int NC_W     = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
    localparam int W_W      = 24;
    localparam int POS_W    = 32;
    localparam int H_W      = 32;
    localparam int CIDX_W   = 12;
    localparam int CORNER_W = 2;
    localparam int CORNERS  = 4;

    // corner bank numbers
    localparam int CORNER_X0Z0 = 0;
    localparam int CORNER_X0Z1 = 1;
    localparam int CORNER_X1Z0 = 2;
    localparam int CORNER_X1Z1 = 3;

    localparam int OFS_W  = POS_W + 1;        // origin-relative offset
    localparam int FAC_W  = W_W + 1;          // in-cell offset / weight
    localparam int DIF_W  = H_W + 1;          // corner height difference
    localparam int LO_W   = 16;               // low slice of a difference
    localparam int HI_W   = DIF_W - LO_W;
    localparam int PP_W   = HI_W + FAC_W;     // partial product
    localparam int PROD_W = DIF_W + FAC_W;    // full product
    localparam int DQ_W   = 34;               // divider quotient bits
    localparam int DD_W   = PROD_W - 1;       // divider dividend magnitude
    localparam int SUM_W  = DQ_W + 2;         // final height sum

    localparam int QDEPTH = 4;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = QP_W + 1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_CELL_COUNT = 2'd0,
        CFG_CELL_WIDTH = 2'd1,
        CFG_ORIGIN_X   = 2'd2,
        CFG_ORIGIN_Z   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]        cell_count;
        logic [W_W-1:0]          cell_width;
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_z;
    } t_cfg;

    typedef struct packed {
        t_op                     op;
        logic signed [OFS_W-1:0] rx;
        logic signed [OFS_W-1:0] rz;
        logic [CIDX_W-1:0]       cell_idx;
        logic [CORNER_W-1:0]     corner;
        logic [H_W-1:0]          data;
    } t_item;

endpackage

`default_nettype wire

/* sv/gthq_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gthq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/gthq_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module gthq_div import gthq_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [W_W-1:0]  i_divisor,
    input  wire logic [DD_W-1:0] i_dividend,
    output logic      [DQ_W-1:0] o_quot,
    output logic      [W_W-1:0]  o_rem
);

    // quotient is known to fit in DQ_W bits, so the top bits seed the remainder
    logic [DQ_W-1:0][W_W-1:0]  r_rem;
    logic [DQ_W-1:0][DQ_W-1:0] r_low;
    logic [DQ_W-1:0][DQ_W-1:0] r_quo;
    logic [DQ_W-1:0][W_W-1:0]  s_rem;
    logic [DQ_W-1:0][DQ_W-1:0] s_low;
    logic [DQ_W-1:0][DQ_W-1:0] s_quo;

    assign s_rem[0] = W_W'(i_dividend[DD_W-1:DQ_W]);
    assign s_low[0] = i_dividend[DQ_W-1:0];
    assign s_quo[0] = '0;

    for (genvar k = 0; k < DQ_W; k++) begin : g_stage
        logic [W_W:0] trial;
        logic         ge;

        if (k > 0) begin : g_link
            assign s_rem[k] = r_rem[k-1];
            assign s_low[k] = r_low[k-1];
            assign s_quo[k] = r_quo[k-1];
        end

        assign trial = {s_rem[k], s_low[k][DQ_W-1]};
        assign ge    = trial >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? W_W'(trial - {1'b0, i_divisor}) : W_W'(trial);
                r_low[k] <= {s_low[k][DQ_W-2:0], 1'b0};
                r_quo[k] <= {s_quo[k][DQ_W-2:0], ge};
            end
        end
    end

    assign o_quot = r_quo[DQ_W-1];
    assign o_rem  = r_rem[DQ_W-1];

endmodule

`default_nettype wire

/* sv/gthq_front.sv */
// Input side: takes items, forms origin-relative offsets, queues them.
`default_nettype none

module gthq_front import gthq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_op,
    input  wire logic signed [POS_W-1:0] i_x_pos,
    input  wire logic signed [POS_W-1:0] i_z_pos,
    input  wire logic [CIDX_W-1:0]       i_cell_index,
    input  wire logic [CORNER_W-1:0]     i_corner,
    input  wire logic signed [H_W-1:0]   i_corner_height,
    input  wire logic                    i_pop,
    output logic                         o_q_valid,
    output t_item                        o_q_item
);

    t_item            r_mem [QDEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;
    t_item            n_item;
    logic             push;
    logic             pop;

    assign o_ready   = r_cnt != QC_W'(QDEPTH);
    assign o_q_valid = r_cnt != '0;
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_pop && o_q_valid;

    always_comb begin
        n_item.op       = t_op'(i_op);
        n_item.rx       = OFS_W'(i_x_pos) - OFS_W'(i_cfg.origin_x);
        n_item.rz       = OFS_W'(i_z_pos) - OFS_W'(i_cfg.origin_z);
        n_item.cell_idx = i_cell_index;
        n_item.corner   = i_corner;
        n_item.data     = i_corner_height;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QP_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QP_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QC_W'(1);
                2'b01:   r_cnt <= r_cnt - QC_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/gthq_back.sv */
// Execution pipeline: cell lookup, corner store, weighting and height sum.
`default_nettype none

module gthq_back import gthq_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [H_W-1:0]      o_height_out,
    output logic                       o_outside
);

    typedef struct packed {
        t_op                 op;
        logic                sx;
        logic                sz;
        logic [CIDX_W-1:0]   cell_idx;
        logic [CORNER_W-1:0] corner;
        logic [H_W-1:0]      data;
    } t_side1;

    typedef struct packed {
        t_op                   op;
        logic                  miss;
        logic signed [H_W-1:0] base;
        logic                  sa;
        logic                  sb;
    } t_side2;

    localparam logic signed [SUM_W-1:0] H_MAX = {{(SUM_W-H_W+1){1'b0}}, {(H_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] H_MIN = {{(SUM_W-H_W+1){1'b1}}, {(H_W-1){1'b0}}};

    logic en;
    logic [NC_W-1:0] n_cells;

    // stage A
    logic   r_a_vld;
    t_item  r_a_item;
    logic [OFS_W-1:0] a_mag_x, a_mag_z;
    t_side1 a_side;

    // divider 1
    logic [DQ_W-1:0] d1_qx, d1_qz;
    logic [W_W-1:0]  d1_rx, d1_rz;
    logic [DQ_W-1:0] r_d1_vld;
    t_side1          r_d1_side [DQ_W];
    t_side1          s1;

    // stage B
    logic                    r_b_vld;
    t_op                     r_b_op;
    logic                    r_b_miss;
    logic [IDX_W-1:0]        r_b_nx, r_b_nz;
    logic signed [FAC_W-1:0] r_b_dx, r_b_dz;
    logic [CELL_AW-1:0]      r_b_wcell;
    logic                    r_b_wok;
    logic [CORNER_W-1:0]     r_b_corner;
    logic [H_W-1:0]          r_b_data;
    logic                    b_miss;
    logic [31:0]             b_wcell_x;

    // stage C and corner store
    logic                    r_c_vld;
    t_op                     r_c_op;
    logic                    r_c_miss;
    logic                    r_c_upper;
    logic signed [FAC_W-1:0] r_c_dx, r_c_dz;
    logic [31:0]             c_cell_x;
    logic [CELL_AW-1:0]      c_raddr;
    logic signed [FAC_W:0]   c_sum;
    logic [CORNERS-1:0]      ram_we;
    logic [H_W-1:0]          ram_rd [CORNERS];

    // stage E (partial products)
    logic                    r_e_vld;
    t_op                     r_e_op;
    logic                    r_e_miss;
    logic signed [H_W-1:0]   r_e_base;
    logic signed [PP_W-1:0]  r_e_pa_lo, r_e_pa_hi, r_e_pb_lo, r_e_pb_hi;
    logic signed [H_W-1:0]   h0, h1, h2, h3, e_base;
    logic signed [DIF_W-1:0] e_a, e_b;
    logic signed [FAC_W-1:0] e_w, e_fa, e_fb;

    // stage F (product magnitude)
    logic                     r_f_vld;
    t_side2                   r_f_side;
    logic [DD_W-1:0]          r_f_mag_a, r_f_mag_b;
    logic signed [PROD_W-1:0] f_pa, f_pb;
    logic signed [PROD_W-1:0] f_ma, f_mb;

    // divider 2 and output
    logic [DQ_W-1:0]         d2_qa, d2_qb;
    logic [W_W-1:0]          d2_ra, d2_rb;
    logic [DQ_W-1:0]         r_d2_vld;
    t_side2                  r_d2_side [DQ_W];
    t_side2                  s2;
    logic signed [SUM_W-1:0] o_qa, o_qb, o_sum, o_sat;
    logic                    r_o_vld;
    logic signed [H_W-1:0]   r_o_height;
    logic                    r_o_outside;

    // whole pipeline advances unless a finished result is held
    assign en    = !r_o_vld || i_ready;
    assign o_pop = en;

    assign n_cells = (NC_W'(i_cfg.cell_count) > NC_W'(MAX_CELLS)) ?
                     NC_W'(MAX_CELLS) : NC_W'(i_cfg.cell_count);

    // ---------------- stage A ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item <= i_q_item;
        end
    end

    assign a_mag_x = r_a_item.rx[OFS_W-1] ? OFS_W'(-r_a_item.rx) : r_a_item.rx;
    assign a_mag_z = r_a_item.rz[OFS_W-1] ? OFS_W'(-r_a_item.rz) : r_a_item.rz;

    always_comb begin
        a_side.op       = r_a_item.op;
        a_side.sx       = r_a_item.rx[OFS_W-1];
        a_side.sz       = r_a_item.rz[OFS_W-1];
        a_side.cell_idx = r_a_item.cell_idx;
        a_side.corner   = r_a_item.corner;
        a_side.data     = r_a_item.data;
    end

    gthq_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_divisor  (i_cfg.cell_width),
        .i_dividend (DD_W'(a_mag_x)),
        .o_quot     (d1_qx),
        .o_rem      (d1_rx)
    );

    gthq_div u_div_z (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_divisor  (i_cfg.cell_width),
        .i_dividend (DD_W'(a_mag_z)),
        .o_quot     (d1_qz),
        .o_rem      (d1_rz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= '0;
        end else if (en) begin
            r_d1_vld <= {r_d1_vld[DQ_W-2:0], r_a_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_side[0] <= a_side;
            for (int k = 1; k < DQ_W; k++) begin
                r_d1_side[k] <= r_d1_side[k-1];
            end
        end
    end

    // ---------------- stage B: cell and in-cell offset ----------------
    assign s1 = r_d1_side[DQ_W-1];

    assign b_miss = (i_cfg.cell_width == '0) || (n_cells == '0)
                 || (s1.sx && d1_qx != '0) || (d1_qx >= DQ_W'(n_cells))
                 || (s1.sz && d1_qz != '0) || (d1_qz >= DQ_W'(n_cells));
    assign b_wcell_x = 32'(s1.cell_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_d1_vld[DQ_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_op     <= s1.op;
            r_b_miss   <= b_miss;
            r_b_nx     <= d1_qx[IDX_W-1:0];
            r_b_nz     <= d1_qz[IDX_W-1:0];
            r_b_dx     <= s1.sx ? -$signed({1'b0, d1_rx}) : $signed({1'b0, d1_rx});
            r_b_dz     <= s1.sz ? -$signed({1'b0, d1_rz}) : $signed({1'b0, d1_rz});
            r_b_wcell  <= b_wcell_x[CELL_AW-1:0];
            r_b_wok    <= b_wcell_x < 32'(STORE_CELLS);
            r_b_corner <= s1.corner;
            r_b_data   <= s1.data;
        end
    end

    // ---------------- stage C: corner store access ----------------
    assign c_cell_x = 32'(r_b_nz) * 32'(n_cells) + 32'(r_b_nx);
    assign c_raddr  = c_cell_x[CELL_AW-1:0];
    assign c_sum    = (FAC_W+1)'(r_b_dx) + (FAC_W+1)'(r_b_dz);

    for (genvar k = 0; k < CORNERS; k++) begin : g_bank
        assign ram_we[k] = en && r_b_vld && (r_b_op == OP_WRITE) && r_b_wok
                        && (r_b_corner == CORNER_W'(k));

        gthq_ram #(
            .WIDTH (H_W),
            .DEPTH (STORE_CELLS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[k]),
            .i_waddr (r_b_wcell),
            .i_wdata (r_b_data),
            .i_re    (en),
            .i_raddr (c_raddr),
            .o_rdata (ram_rd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_op    <= r_b_op;
            r_c_miss  <= r_b_miss;
            r_c_upper <= c_sum > $signed({2'b00, i_cfg.cell_width});
            r_c_dx    <= r_b_dx;
            r_c_dz    <= r_b_dz;
        end
    end

    // ---------------- stage E: triangle pick and partial products ----------------
    assign h0 = $signed(ram_rd[CORNER_X0Z0]);
    assign h1 = $signed(ram_rd[CORNER_X0Z1]);
    assign h2 = $signed(ram_rd[CORNER_X1Z0]);
    assign h3 = $signed(ram_rd[CORNER_X1Z1]);
    assign e_w = $signed({1'b0, i_cfg.cell_width});

    always_comb begin
        if (r_c_upper) begin
            e_base = h3;
            e_a    = DIF_W'(h1) - DIF_W'(h3);
            e_b    = DIF_W'(h2) - DIF_W'(h3);
            e_fa   = e_w - r_c_dx;
            e_fb   = e_w - r_c_dz;
        end else begin
            e_base = h0;
            e_a    = DIF_W'(h2) - DIF_W'(h0);
            e_b    = DIF_W'(h1) - DIF_W'(h0);
            e_fa   = r_c_dx;
            e_fb   = r_c_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_op    <= r_c_op;
            r_e_miss  <= r_c_miss;
            r_e_base  <= e_base;
            r_e_pa_lo <= $signed({1'b0, e_a[LO_W-1:0]}) * e_fa;
            r_e_pa_hi <= $signed(e_a[DIF_W-1:LO_W]) * e_fa;
            r_e_pb_lo <= $signed({1'b0, e_b[LO_W-1:0]}) * e_fb;
            r_e_pb_hi <= $signed(e_b[DIF_W-1:LO_W]) * e_fb;
        end
    end

    // ---------------- stage F: product, sign and magnitude ----------------
    assign f_pa = (PROD_W'(r_e_pa_hi) <<< LO_W) + PROD_W'(r_e_pa_lo);
    assign f_pb = (PROD_W'(r_e_pb_hi) <<< LO_W) + PROD_W'(r_e_pb_lo);
    assign f_ma = f_pa[PROD_W-1] ? -f_pa : f_pa;
    assign f_mb = f_pb[PROD_W-1] ? -f_pb : f_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side.op   <= r_e_op;
            r_f_side.miss <= r_e_miss;
            r_f_side.base <= r_e_base;
            r_f_side.sa   <= f_pa[PROD_W-1];
            r_f_side.sb   <= f_pb[PROD_W-1];
            r_f_mag_a     <= f_ma[DD_W-1:0];
            r_f_mag_b     <= f_mb[DD_W-1:0];
        end
    end

    gthq_div u_div_a (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_divisor  (i_cfg.cell_width),
        .i_dividend (r_f_mag_a),
        .o_quot     (d2_qa),
        .o_rem      (d2_ra)
    );

    gthq_div u_div_b (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_divisor  (i_cfg.cell_width),
        .i_dividend (r_f_mag_b),
        .o_quot     (d2_qb),
        .o_rem      (d2_rb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_vld <= '0;
        end else if (en) begin
            r_d2_vld <= {r_d2_vld[DQ_W-2:0], r_f_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_side[0] <= r_f_side;
            for (int k = 1; k < DQ_W; k++) begin
                r_d2_side[k] <= r_d2_side[k-1];
            end
        end
    end

    // ---------------- output: sum, saturate, hold ----------------
    assign s2    = r_d2_side[DQ_W-1];
    assign o_qa  = s2.sa ? -$signed({2'b00, d2_qa}) : $signed({2'b00, d2_qa});
    assign o_qb  = s2.sb ? -$signed({2'b00, d2_qb}) : $signed({2'b00, d2_qb});
    assign o_sum = SUM_W'(s2.base) + o_qa + o_qb;
    assign o_sat = (o_sum > H_MAX) ? H_MAX : ((o_sum < H_MIN) ? H_MIN : o_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_d2_vld[DQ_W-1] && (s2.op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_outside <= s2.miss;
            r_o_height  <= s2.miss ? '0 : o_sat[H_W-1:0];
        end
    end

    assign o_valid      = r_o_vld;
    assign o_height_out = r_o_height;
    assign o_outside    = r_o_outside;

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_outside) |-> (r_o_height == '0))
        else $error("miss result with nonzero height");

    a_one_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ram_we))
        else $error("more than one corner bank written");

    a_wr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we != '0) |-> (r_b_op == OP_WRITE))
        else $error("corner store written by a query");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_c_vld) && $stable(r_d1_vld) && $stable(r_d2_vld)))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

/* sv/grid_triangle_height_query_core.sv */
// Top level: configuration registers, input queue and execution pipeline.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_op i_x_pos i_z_pos i_cell_index
//          |            |             | i_corner i_corner_height
//  out     | o_out_valid| i_out_ready | o_height_out o_outside
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index i_cfg_data
//
// One item per cycle sustained while the output is not stalled. A query result
// passes the queue, two 34-stage restoring divider rows (cell lookup, then
// weighting) and the single stages A, B, C, E, F and the output register.
// Writes give no result; they update the corner store in pipeline order.
// i_rst_n is synchronous, active low; the corner store is not cleared.
// An output stall freezes the whole pipeline; the 4-entry queue keeps accepting until full.
`default_nettype none

module grid_triangle_height_query_core import gthq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item input
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_op,
    input  wire logic signed [POS_W-1:0] i_x_pos,
    input  wire logic signed [POS_W-1:0] i_z_pos,
    input  wire logic [CIDX_W-1:0]       i_cell_index,
    input  wire logic [CORNER_W-1:0]     i_corner,
    input  wire logic signed [H_W-1:0]   i_corner_height,
    // result output
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [H_W-1:0]        o_height_out,
    output logic                         o_outside,
    // register writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // registers always take a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_count <= CNT_W'(1);
            r_cfg.cell_width <= W_W'(256);     // 1.0 in 8 fraction bits
            r_cfg.origin_x   <= '0;
            r_cfg.origin_z   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CELL_COUNT: r_cfg.cell_count <= i_cfg_data[CNT_W-1:0];
                CFG_CELL_WIDTH: r_cfg.cell_width <= i_cfg_data[W_W-1:0];
                CFG_ORIGIN_X:   r_cfg.origin_x   <= $signed(i_cfg_data[POS_W-1:0]);
                CFG_ORIGIN_Z:   r_cfg.origin_z   <= $signed(i_cfg_data[POS_W-1:0]);
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // front: origin subtraction and item queue
    gthq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_op            (i_op),
        .i_x_pos         (i_x_pos),
        .i_z_pos         (i_z_pos),
        .i_cell_index    (i_cell_index),
        .i_corner        (i_corner),
        .i_corner_height (i_corner_height),
        .i_pop           (q_pop),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item)
    );

    // back: cell divide, store access, interpolation
    gthq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_height_out (o_height_out),
        .o_outside    (o_outside)
    );

endmodule

`default_nettype wire

/* sim/grid_triangle_height_query_core_tb.sv */
// Self-checking testbench for the grid triangle height query core.
`default_nettype none

module grid_triangle_height_query_core_tb;
    import gthq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;   // covers the query pipeline depth
    localparam int HOLD_CYCLES  = 400;   // long output hold-off for pressure test
    localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before timeout

    typedef struct {
        logic signed [H_W-1:0] height;
        logic                  miss;
    } t_height_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_op = OP_WRITE;
    logic signed [POS_W-1:0] i_x_pos = '0;
    logic signed [POS_W-1:0] i_z_pos = '0;
    logic [CIDX_W-1:0]       i_cell_index = '0;
    logic [CORNER_W-1:0]     i_corner = '0;
    logic signed [H_W-1:0]   i_corner_height = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [H_W-1:0]   o_height_out;
    logic                    o_outside;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index = '0;
    logic [31:0]             i_cfg_data = '0;

    grid_triangle_height_query_core dut (.*);

    always #4 i_clk = ~i_clk;

    // Own copy of the block state and registers.
    int          corner_store [STORE_CELLS*CORNERS];
    bit          corner_written [STORE_CELLS*CORNERS];
    logic [6:0]  cfg_cells;
    logic [23:0] cfg_width;
    int          cfg_org_x;
    int          cfg_org_z;

    t_height_result height_expect_q [$];

    int err_count;
    int send_idle_pct;
    int sink_stall_pct;
    bit hold_request;

    // Expected outcome of one query under the current registers.
    function automatic void predict_height(input int x, input int z, output bit miss,
                                           output int cell_no, output int height);
        longint n, w, rx, rz, nx, nz, dx, dz, h, h0, h1, h2, h3;
        n = (cfg_cells > MAX_CELLS) ? MAX_CELLS : cfg_cells;
        w = cfg_width;
        miss = 1'b1;
        cell_no = 0;
        height = 0;
        if (w == 0 || n == 0) return;
        rx = longint'(x) - longint'(cfg_org_x);
        rz = longint'(z) - longint'(cfg_org_z);
        nx = rx / w;
        nz = rz / w;
        if (nx < 0 || nx >= n || nz < 0 || nz >= n) return;
        miss = 1'b0;
        dx = rx - nx * w;
        dz = rz - nz * w;
        cell_no = int'(nz * n + nx);
        h0 = corner_store[cell_no*4 + CORNER_X0Z0];
        h1 = corner_store[cell_no*4 + CORNER_X0Z1];
        h2 = corner_store[cell_no*4 + CORNER_X1Z0];
        h3 = corner_store[cell_no*4 + CORNER_X1Z1];
        // lower triangle when the in-cell offsets sum to at most one width
        if (dx + dz <= w)
            h = h0 + (h2 - h0) * dx / w + (h1 - h0) * dz / w;
        else
            h = h3 + (h1 - h3) * (w - dx) / w + (h2 - h3) * (w - dz) / w;
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        height = int'(h);
    endfunction

    // Offers one item and waits for it; valid stays high for a following item.
    task automatic send_item(input logic op, input int x, input int z, input int cell_no,
                             input int corner, input int height);
        bit miss;
        int hit_cell;
        int h;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_x_pos         <= x;
        i_z_pos         <= z;
        i_cell_index    <= cell_no[CIDX_W-1:0];
        i_corner        <= corner[CORNER_W-1:0];
        i_corner_height <= height;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_WRITE) begin
            corner_store[cell_no[CIDX_W-1:0]*4 + corner[1:0]] = height;
        end else begin
            predict_height(x, z, miss, hit_cell, h);
            height_expect_q.push_back('{height: h, miss: miss});
        end
    endtask

    task automatic write_corner(input int cell_no, input int corner, input int height);
        corner_written[cell_no*4 + corner] = 1'b1;
        send_item(OP_WRITE, $urandom, $urandom, cell_no, corner, height);
    endtask

    // Fills any corner never written in the hit cell, then sends the query.
    task automatic send_query(input int x, input int z);
        bit miss;
        int cell_no;
        int h;
        predict_height(x, z, miss, cell_no, h);
        if (!miss)
            for (int c = 0; c < CORNERS; c++)
                if (!corner_written[cell_no*4 + c]) write_corner(cell_no, c, $urandom);
        send_item(OP_QUERY, x, z, $urandom, $urandom, $urandom);
    endtask

    // Lets the pipeline empty out before registers change.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (height_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int cells, input int width, input int org_x,
                              input int org_z);
        int data [4];
        data = '{cells, width, org_x, org_z};
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[1:0];
            // upper bits beyond the register width are noise
            i_cfg_data  <= (r < 2) ? (data[r] | ($urandom & 32'hFF00_0000)) : data[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(r[1:0]))
                CFG_CELL_COUNT: cfg_cells = data[r][6:0];
                CFG_CELL_WIDTH: cfg_width = data[r][23:0];
                CFG_ORIGIN_X:   cfg_org_x = data[r];
                default:        cfg_org_z = data[r];
            endcase
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Position near the grid along one axis, sometimes just outside it.
    function automatic int pick_coord(input int origin);
        longint n, w, off, pos;
        n = (cfg_cells > MAX_CELLS) ? MAX_CELLS : cfg_cells;
        w = cfg_width;
        if (n == 0 || w == 0) return $urandom;
        off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (n * w + 2 * w + 1) - w;
        pos = longint'(origin) + off;
        if (pos > 64'sd2147483647) pos = 64'sd2147483647;
        if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        return int'(pos);
    endfunction

    task automatic test_default_registers();
        send_query(0, 0);
        send_query(128, 64);
        send_query(255, 255);     // far corner, upper triangle
        send_query(200, 100);
        send_query(256, 0);       // one past the block: miss
        send_query(-1, -255);     // slightly negative: extrapolated cell 0
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_height_saturation();
        write_corner(0, CORNER_X0Z0, 32'h7FFF_FFFF);
        write_corner(0, CORNER_X0Z1, 32'h7FFF_FFFF);
        write_corner(0, CORNER_X1Z0, 32'h8000_0000);
        write_corner(0, CORNER_X1Z1, 32'h8000_0000);
        send_query(-255, 0);      // overflow high
        send_query(0, 0);
        send_query(255, 10);      // upper triangle
        write_corner(0, CORNER_X0Z0, 32'h8000_0000);
        write_corner(0, CORNER_X1Z0, 32'h7FFF_FFFF);
        send_query(-255, -255);   // overflow low
    endtask

    task automatic test_register_extremes();
        set_config(127, 24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);   // count saturates
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h8000_0000 + 24'hFF_FFFF * 63 + 5, 32'h7FFF_FFFF);
        write_corner(4095, CORNER_X1Z1, 32'h1234_5678);
        set_config(64, 256, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h8000_0000 + 256 * 64 - 1);
        set_config(0, 256, 0, 0);                                   // no cells: miss
        send_query(10, 10);
        set_config(8, 0, 0, 0);                                     // zero width: miss
        send_query(0, 0);
        set_config(1, 1, 0, 0);
        send_query(0, 0);
    endtask

    task automatic test_random(input int items, input int idle, input int stall);
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        for (int k = 0; k < items; k++) begin
            case ($urandom_range(9))
                0:       send_item(OP_WRITE, $urandom, $urandom, $urandom, $urandom,
                                   $urandom);
                1:       send_query($urandom, $urandom);
                default: send_query(pick_coord(cfg_org_x), pick_coord(cfg_org_z));
            endcase
            // random writes may have touched unmarked cells; mark them for reuse
            if (i_op == OP_WRITE) corner_written[i_cell_index*4 + i_corner] = 1'b1;
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b1;
        for (int k = 0; k < 60; k++)
            send_query(pick_coord(cfg_org_x), pick_coord(cfg_org_z));
    endtask

    // Result side: ready pattern, long hold-off on request, and field checks.
    int hold_count;
    always @(posedge i_clk) begin
        t_height_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (height_expect_q.size() == 0) begin
                $error("result with no query outstanding: height_out=%0d outside=%0b",
                       o_height_out, o_outside);
                err_count++;
            end else begin
                exp_r = height_expect_q.pop_front();
                if (o_outside !== exp_r.miss) begin
                    $error("outside: expected %0b, got %0b", exp_r.miss, o_outside);
                    err_count++;
                end
                if (o_height_out !== exp_r.height) begin
                    $error("height_out: expected %0d, got %0d", exp_r.height, o_height_out);
                    err_count++;
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_count   = HOLD_CYCLES;
        end
        if (hold_count > 0) begin
            hold_count--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Timeout on a long stretch with no handshake on any channel.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("grid_triangle_height_query_core verification failed");
            $finish;
        end
    end

    initial begin
        cfg_cells = 7'd1;
        cfg_width = 24'd256;
        cfg_org_x = 0;
        cfg_org_z = 0;
        err_count = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b0;
        hold_count     = 0;
        quiet_cycles   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_registers();
        test_height_saturation();
        test_register_extremes();

        // queries into fresh cells also send their four corner writes
        set_config(1, 256, 0, 0);
        test_random(50, 0, 0);
        set_config(64, 256, -1000, 5000);
        test_random(50, 71, 0);
        set_config(16, 24'hFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        test_random(50, 0, 71);
        set_config(127, 3, 32'h7FFF_0000, -20);
        test_random(50, 35, 35);
        set_config(5, 1000, 123456, -654321);
        test_output_backpressure();

        wait_idle();
        if (err_count == 0)
            $display("grid_triangle_height_query_core verification clean");
        else
            $display("grid_triangle_height_query_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
